### design/bounded_singly_linked_list_top_defines.svh
// Assertion macros for the linked-list node pool.
`ifndef BOUNDED_SINGLY_LINKED_LIST_TOP_DEFINES_SVH
`define BOUNDED_SINGLY_LINKED_LIST_TOP_DEFINES_SVH

// Condition that holds at every edge outside reset.
`define BSLL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define BSLL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BSLL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bsll_pkg.sv
// Shared constants and types for the linked-list node pool.
`timescale 1ns / 1ps
`default_nettype none

package bsll_pkg;

  localparam int POOL_DEPTH_DEF = 16;

  localparam int CMD_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 40;
  localparam int M_PAD_W    = M_TDATA_W - VALUE_W - STATUS_W - COUNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_VALUE = 3'd3,
    CMD_LIST      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

### design/bsll_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bsll_ram import bsll_pkg::*; #(
  parameter int WIDTH = VALUE_W,
  parameter int DEPTH = POOL_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/bsll_alloc.sv
// Lowest free node finder over the free map, registered.
`timescale 1ns / 1ps
`default_nettype none

module bsll_alloc import bsll_pkg::*; #(
  parameter int DEPTH = POOL_DEPTH_DEF,
  localparam int IW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic [DEPTH-1:0] free_map,
  output logic      [IW-1:0]    free_idx,
  output logic                  full
);

  logic [IW-1:0] idx_c;
  logic          found_c;

  always_comb begin
    idx_c   = '0;
    found_c = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        idx_c   = IW'(i);
        found_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    free_idx <= idx_c;
    full     <= !found_c;
  end

endmodule

`default_nettype wire

### design/bounded_singly_linked_list_top.sv
// Top level: singly linked list kept in a node pool of two RAMs.
// Insert: S_INS writes the new node, then S_EMIT (insert at back on a non-empty list adds S_INS_TAIL).
// Remove front: S_RF, then S_EMIT. Remove by value: S_RV walks one node per step, up to POOL_DEPTH nodes.
// List: one result per cycle while the output is not stalled; the walk does one link RAM read per node.
// One command at a time; a new input is taken while the last result waits on the output.
// Synchronous reset empties the list and frees all nodes; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_singly_linked_list_top_defines.svh"

module bounded_singly_linked_list_top import bsll_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // command[2:0], value[34:3], zero pad
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // value_res[31:0], status[33:32],
                                               // count[38:34], zero pad
  output logic                      m_tlast
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS      = 8'b0000_0010,
    S_INS_TAIL = 8'b0000_0100,
    S_RF       = 8'b0000_1000,
    S_RV       = 8'b0001_0000,
    S_LS       = 8'b0010_0000,
    S_EMIT     = 8'b0100_0000
  } state_t;

  state_t                state, state_next;
  cmd_t                  cmd, cmd_next;
  logic [VALUE_W-1:0]    val, val_next;
  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         tail, tail_next;
  logic [IW-1:0]         cur, cur_next;
  logic [IW-1:0]         prev, prev_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         walk, walk_next;
  logic [POOL_DEPTH-1:0] free_map, free_map_next;
  logic [VALUE_W-1:0]    res_val, res_val_next;
  status_t               res_st, res_st_next;

  logic               v_we;
  logic [IW-1:0]      v_waddr;
  logic [VALUE_W-1:0] v_wdata;
  logic               l_we;
  logic [IW-1:0]      l_waddr;
  logic [IW-1:0]      l_wdata;
  logic [IW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_value;
  logic [IW-1:0]      rd_link;

  logic [IW-1:0] free_idx;
  logic          pool_full;

  logic               out_free;
  logic               out_load;
  logic [VALUE_W-1:0] out_val;
  status_t            out_st;
  logic               out_last;
  cmd_t               in_cmd;

  bsll_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (rd_addr),
    .rdata (rd_value)
  );

  bsll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (rd_addr),
    .rdata (rd_link)
  );

  bsll_alloc #(.DEPTH(POOL_DEPTH)) u_alloc (
    .clk      (clk),
    .free_map (free_map),
    .free_idx (free_idx),
    .full     (pool_full)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    val_next      = val;
    head_next     = head;
    tail_next     = tail;
    cur_next      = cur;
    prev_next     = prev;
    count_next    = count;
    walk_next     = walk;
    free_map_next = free_map;
    res_val_next  = res_val;
    res_st_next   = res_st;
    v_we          = 1'b0;
    v_waddr       = free_idx;
    v_wdata       = val;
    l_we          = 1'b0;
    l_waddr       = free_idx;
    l_wdata       = '0;
    rd_addr       = head;
    out_load      = 1'b0;
    out_val       = '0;
    out_st        = ST_OK;
    out_last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_next     = in_cmd;
          val_next     = s_tdata[CMD_W +: VALUE_W];
          cur_next     = head;
          prev_next    = '0;
          walk_next    = CW'(1);
          res_val_next = '0;
          res_st_next  = ST_OK;
          unique case (in_cmd)
            CMD_INS_FRONT, CMD_INS_BACK: state_next = S_INS;
            CMD_REM_FRONT, CMD_REM_VALUE, CMD_LIST: begin
              if (count == '0) begin
                res_st_next = ST_EMPTY;
                state_next  = S_EMIT;
              end else if (in_cmd == CMD_REM_FRONT) begin
                state_next = S_RF;
              end else if (in_cmd == CMD_REM_VALUE) begin
                state_next = S_RV;
              end else begin
                state_next = S_LS;
              end
            end
            default: state_next = S_EMIT;
          endcase
        end
      end

      S_INS: begin
        state_next = S_EMIT;
        if (pool_full) begin
          res_st_next = ST_FULL;
        end else begin
          v_we                    = 1'b1;
          l_we                    = 1'b1;
          free_map_next[free_idx] = 1'b0;
          count_next              = count + CW'(1);
          if (count == '0) begin
            head_next = free_idx;
            tail_next = free_idx;
          end else if (cmd == CMD_INS_FRONT) begin
            l_wdata   = head;
            head_next = free_idx;
          end else begin
            prev_next  = tail;
            tail_next  = free_idx;
            state_next = S_INS_TAIL;
          end
        end
      end

      S_INS_TAIL: begin
        l_we       = 1'b1;
        l_waddr    = prev;
        l_wdata    = tail;
        state_next = S_EMIT;
      end

      S_RF: begin
        res_val_next        = rd_value;
        free_map_next[head] = 1'b1;
        count_next          = count - CW'(1);
        if (count == CW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          head_next = rd_link;
        end
        state_next = S_EMIT;
      end

      S_RV: begin
        if (rd_value == val) begin
          free_map_next[cur] = 1'b1;
          count_next         = count - CW'(1);
          if (count == CW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else if (walk == CW'(1)) begin
            head_next = rd_link;
          end else begin
            l_we    = 1'b1;
            l_waddr = prev;
            l_wdata = rd_link;
            if (cur == tail) begin
              tail_next = prev;
            end
          end
          state_next = S_EMIT;
        end else if (walk == count) begin
          res_st_next = ST_NOTFOUND;
          state_next  = S_EMIT;
        end else begin
          prev_next = cur;
          cur_next  = rd_link;
          walk_next = walk + CW'(1);
          rd_addr   = rd_link;
        end
      end

      S_LS: begin
        rd_addr = cur;
        if (out_free) begin
          out_load = 1'b1;
          out_val  = rd_value;
          out_last = (walk == count);
          if (walk == count) begin
            state_next = S_IDLE;
          end else begin
            cur_next  = rd_link;
            walk_next = walk + CW'(1);
            rd_addr   = rd_link;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_val    = res_val;
          out_st     = res_st;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      free_map <= '1;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      free_map <= free_map_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    val     <= val_next;
    cur     <= cur_next;
    prev    <= prev_next;
    walk    <= walk_next;
    res_val <= res_val_next;
    res_st  <= res_st_next;
    if (out_load) begin
      m_tdata <= {{M_PAD_W{1'b0}}, COUNT_W'(count), out_st, out_val};
      m_tlast <= out_last;
    end
  end

  `BSLL_ASSERT_ALWAYS(a_count_bound, count <= CW'(POOL_DEPTH), "entry count above pool depth")
  `BSLL_ASSERT_IMP(a_empty_ptrs, count == '0, head == '0 && tail == '0, "empty list with nonzero head or tail")
  `BSLL_ASSERT_ALWAYS(a_free_cons, $countones(free_map) + int'(count) == POOL_DEPTH, "free map and entry count disagree")
  `BSLL_ASSERT_NXT(a_list_hold, state == S_LS && !out_free, state == S_LS && $stable(cur) && $stable(walk), "list walk moved while output stalled")

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the node-pool linked list: random commands, shadow list, stream checks.
`timescale 1ns / 1ps

module tb_top;
  import bsll_pkg::*;

  localparam int NODES = POOL_DEPTH_DEF;
  localparam int CLK_HALF = 10;
  localparam int QUIET_TAIL = 40;
  localparam int HOLD_AFTER = 45;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] v;
  } list_cmd_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  bounded_singly_linked_list_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int mismatches = 0;
  int items_taken = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // shadow of the pool
  logic [VALUE_W-1:0] node_val[NODES] = '{default: '0};
  logic [3:0]         node_nxt[NODES] = '{default: '0};
  logic [NODES-1:0]   free_nodes = '1;
  logic [3:0]         head_node = '0;
  logic [3:0]         tail_node = '0;
  logic [COUNT_W-1:0] list_len = '0;

  task automatic push_result(input logic [VALUE_W-1:0] v, input status_t st, input logic lst);
    list_result_t r;
    r.value = v;
    r.status = st;
    r.count = list_len;
    r.last = lst;
    expected_results.push_back(r);
  endtask

  task automatic unlink_node(input logic [3:0] n);
    free_nodes[n] = 1'b1;
    list_len = list_len - 1'b1;
    if (list_len == 0) begin
      head_node = '0;
      tail_node = '0;
    end
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v);
    int slot;
    logic [3:0] prv;
    logic [3:0] cur;
    slot = -1;
    if (op == CMD_INS_FRONT || op == CMD_INS_BACK) begin
      for (int i = 0; i < NODES; i++)
        if (free_nodes[i] && slot < 0) slot = i;
      if (slot < 0) begin
        push_result('0, ST_FULL, 1'b1);
      end else begin
        free_nodes[slot] = 1'b0;
        node_val[slot] = v;
        if (list_len == 0) begin
          node_nxt[slot] = '0;
          head_node = 4'(slot);
          tail_node = 4'(slot);
        end else if (op == CMD_INS_FRONT) begin
          node_nxt[slot] = head_node;
          head_node = 4'(slot);
        end else begin
          node_nxt[slot] = '0;
          node_nxt[tail_node] = 4'(slot);
          tail_node = 4'(slot);
        end
        list_len = list_len + 1'b1;
        push_result('0, ST_OK, 1'b1);
      end
    end else if (op == CMD_REM_FRONT || op == CMD_REM_VALUE || op == CMD_LIST) begin
      if (list_len == 0) begin
        push_result('0, ST_EMPTY, 1'b1);
      end else if (op == CMD_REM_FRONT) begin
        cur = head_node;
        head_node = node_nxt[cur];
        unlink_node(cur);
        push_result(node_val[cur], ST_OK, 1'b1);
      end else if (op == CMD_REM_VALUE) begin
        prv = '0;
        cur = head_node;
        for (int i = 0; i < list_len && slot < 0; i++) begin
          if (node_val[cur] == v) begin
            slot = cur;
            if (i == 0) begin
              head_node = node_nxt[cur];
            end else begin
              node_nxt[prv] = node_nxt[cur];
              if (cur == tail_node) tail_node = prv;
            end
            unlink_node(cur);
            push_result('0, ST_OK, 1'b1);
          end
          prv = cur;
          cur = node_nxt[cur];
        end
        if (slot < 0) push_result('0, ST_NOTFOUND, 1'b1);
      end else begin
        cur = head_node;
        for (int i = 0; i < list_len; i++) begin
          push_result(node_val[cur], ST_OK, i + 1 == list_len);
          cur = node_nxt[cur];
        end
      end
    end else begin
      push_result('0, ST_OK, 1'b1);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_command(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: VALUE_W]);
        items_taken <= items_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 99) < 15) begin
          send_gap <= $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          list_cmd_t c;
          c = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {{(S_TDATA_W - VALUE_W - CMD_W){1'b0}}, c.v, c.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: value %h status %0d count %0d last %b",
                     m_tdata[31:0], m_tdata[33:32], m_tdata[38:34], m_tlast);
        end else begin
          list_result_t e;
          e = expected_results.pop_front();
          if (m_tdata[31:0] !== e.value || m_tdata[33:32] !== e.status ||
              m_tdata[38:34] !== e.count || m_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %h status %s count %0d last %b, got %h %0d %0d %b",
                       e.value, e.status.name(), e.count, e.last,
                       m_tdata[31:0], m_tdata[33:32], m_tdata[38:34], m_tlast);
          end
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 99) < 15) begin
        recv_gap <= $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic list_cmd_t make_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v);
    list_cmd_t c;
    c.op = op;
    c.v = v;
    return c;
  endfunction

  initial begin
    logic [VALUE_W-1:0] favorites[6];
    logic [CMD_W-1:0] op;
    logic [VALUE_W-1:0] v;
    int r;
    bit filling;

    favorites = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom};

    // directed: empty cases, extremes, duplicates, tail removal, spare codes
    pending_cmds.push_back(make_cmd(CMD_LIST, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_REM_FRONT, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_INS_FRONT, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(CMD_INS_BACK, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_INS_FRONT, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_INS_BACK, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_INS_BACK, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_LIST, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'h0000_0005));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_LIST, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_REM_FRONT, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_INS_BACK, 32'h5555_5555));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(CMD_SPARE_FIRST, $urandom));
    pending_cmds.push_back(make_cmd(CMD_SPARE_FIRST + 1'b1, $urandom));
    pending_cmds.push_back(make_cmd(CMD_SPARE_LAST, $urandom));
    pending_cmds.push_back(make_cmd(CMD_REM_FRONT, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_REM_FRONT, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_INS_BACK, 32'hAAAA_AAAA));
    pending_cmds.push_back(make_cmd(CMD_LIST, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_REM_VALUE, 32'hAAAA_AAAA));

    // random: opens with a run that overflows the pool, then fill and drain phases
    for (int k = 0; k < 255; k++) begin
      filling = ((k / 40) % 2) == 0;
      r = $urandom_range(0, 99);
      if (k < 18 || r < (filling ? 75 : 20))
        op = $urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT;
      else if (r < (filling ? 82 : 50))
        op = CMD_REM_FRONT;
      else if (r < (filling ? 90 : 75))
        op = CMD_REM_VALUE;
      else if (r < (filling ? 96 : 92))
        op = CMD_LIST;
      else
        op = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      if ($urandom_range(0, 99) < (op == CMD_REM_VALUE ? 80 : 55))
        v = favorites[$urandom_range(0, 5)];
      else
        v = $urandom;
      pending_cmds.push_back(make_cmd(op, v));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(400_000 * 2 * CLK_HALF);
    $display("Verification failed");
    $finish;
  end

endmodule
